// ----- hw/rtl/mtbne_pkg.sv -----
// Package for the music track bytecode decoder: opcode codes, event kinds
// and the packed word types of the input and result channels. No dependencies.
`default_nettype none
package mtbne_pkg;

  localparam logic [7:0] OP_NOTE     = 8'hF4;
  localparam logic [7:0] OP_PROGRAM  = 8'hC2;
  localparam logic [7:0] OP_NOP      = 8'hEE;
  localparam logic [7:0] OP_SKIP2_A  = 8'hFE;
  localparam logic [7:0] OP_SKIP2_B  = 8'hFB;
  localparam logic [7:0] OP_SKIP1_A  = 8'hF8;
  localparam logic [7:0] OP_SKIP1_B  = 8'hF1;
  localparam logic [7:0] OP_SKIP1_C  = 8'hF0;
  localparam logic [7:0] OP_SKIP1_D  = 8'hFA;
  localparam logic [7:0] OP_SKIP1_E  = 8'hBF;
  localparam logic [7:0] OP_SKIP1_F  = 8'hBE;
  localparam logic [7:0] OP_SKIP1_G  = 8'hFF;
  localparam logic [7:0] OP_NONE     = 8'h00;

  localparam logic [7:0] MAX_DATA7     = 8'h7F;
  localparam logic [7:0] LONG_DELAY_TH = 8'd32;
  localparam logic [6:0] DEFAULT_VEL   = 7'd64;

  localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
  localparam logic [1:0] KIND_PROGRAM  = 2'd2;

  localparam logic CFG_TRACK_LENGTH = 1'b0;
  localparam logic CFG_OUT_CHANNEL  = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
    logic       song_start;
  } in_word_t;

  typedef struct packed {
    logic [15:0] event_tick;
    logic [1:0]  event_kind;
    logic [6:0]  note_or_program;
    logic [6:0]  velocity;
    logic [3:0]  event_channel;
    logic        last_of_run;
  } out_word_t;

endpackage
`default_nettype wire

// ----- hw/rtl/music_track_bytecode_to_note_events_core.sv -----
// Top level of the music track bytecode decoder: decode of one track byte per
// cycle while in_ready is high, and a four-entry event queue. Depends on mtbne_pkg.
`default_nettype none
// How to use this block:
// The input channel (in_valid, in_ready, in_data) carries one track byte per
// word, with flags that mark the first byte of a track and of a song. The
// output channel (out_valid, out_ready, out_data) carries note-on, note-off
// and program-change events, each tagged with its tick time and channel.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes the track
// length and the output channel; write it only while the block is idle.
// A byte is decoded in the cycle it is accepted and its zero, one or two
// events enter the event queue at that edge, so the first event is registered
// in the queue and shows on out_data once the events ahead of it have left.
// Throughput is one byte per cycle as long as the queue keeps room for two
// events; the queue drains one event per cycle while out_ready is high, so a
// byte that ends a note adds two events; that drain rate sets the event rate.
// in_ready is high while at least two of the four queue entries are free.
// When the receiver stalls, events stay queued in order and input is held
// off once the queue cannot take another pair.
// Reset (rst, synchronous) empties the queue, clears all decode state and
// sets the track length to 512 and the output channel to 0.
module music_track_bytecode_to_note_events_core #(
  parameter int MAX_TRACK_BYTES = 512,
  parameter int MAX_EVENTS      = 4096
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  mtbne_pkg::in_word_t in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output mtbne_pkg::out_word_t out_data,
  input  wire                 cfg_we,
  input  wire                 cfg_index,
  input  wire  [9:0]          cfg_wdata
);
  import mtbne_pkg::*;

  // The position register is ten bits wide, so the usable length caps there.
  localparam int LEN_CAP = (MAX_TRACK_BYTES > 1023) ? 1023 : MAX_TRACK_BYTES;
  localparam logic [9:0] LEN_CAP_V = LEN_CAP[9:0];
  localparam int EV_LIMIT = MAX_EVENTS - 2;
  localparam logic [31:0] EV_LIMIT_V = EV_LIMIT;

  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);

  // Configuration registers.
  logic [9:0] track_length;
  logic [3:0] out_channel;

  // Decode state.
  logic [9:0]  byte_position, byte_position_next;
  logic [15:0] track_time, track_time_next;
  logic [12:0] events_emitted, events_emitted_next;
  logic [7:0]  pending_opcode, pending_opcode_next;
  logic [1:0]  operand_bytes_left, operand_bytes_left_next;
  logic [7:0]  held_note, held_note_next;
  logic [7:0]  held_duration, held_duration_next;
  logic        track_halted, track_halted_next;

  // Event queue.
  out_word_t      queue [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [PW:0]    count;

  logic       accept, pop;
  logic [1:0] push_n;
  out_word_t  ev0, ev1;

  // Values of the state once the start flags of this byte are applied.
  logic [9:0]  eff_pos;
  logic [15:0] eff_time;
  logic [12:0] eff_events;
  logic [7:0]  eff_pend;
  logic [1:0]  eff_left;
  logic        eff_halt;
  logic [9:0]  len;
  logic [9:0]  room;
  logic [7:0]  b;
  logic [6:0]  vel;
  logic        active;

  assign in_ready  = (count <= (PW+1)'(DEPTH - 2));
  assign accept    = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = queue[rd_ptr];

  assign b   = in_data.data_byte;
  assign len = (track_length > LEN_CAP_V) ? LEN_CAP_V : track_length;
  assign vel = (b == 8'd0 || b > MAX_DATA7) ? DEFAULT_VEL : b[6:0];

  always_comb begin
    eff_pos    = in_data.track_start ? '0 : byte_position;
    eff_time   = in_data.track_start ? '0 : track_time;
    eff_pend   = in_data.track_start ? OP_NONE : pending_opcode;
    eff_left   = in_data.track_start ? '0 : operand_bytes_left;
    eff_halt   = (in_data.track_start || in_data.song_start) ? 1'b0 : track_halted;
    eff_events = in_data.song_start ? '0 : events_emitted;
    active     = !eff_halt && (eff_pos < len);
    room       = len - eff_pos - 10'd1;

    byte_position_next      = eff_pos;
    track_time_next         = eff_time;
    pending_opcode_next     = eff_pend;
    operand_bytes_left_next = eff_left;
    track_halted_next       = eff_halt;
    held_note_next          = held_note;
    held_duration_next      = held_duration;
    push_n                  = 2'd0;

    ev0 = '{event_tick: eff_time, event_kind: KIND_NOTE_ON,
            note_or_program: held_note[6:0], velocity: vel,
            event_channel: out_channel, last_of_run: 1'b0};
    ev1 = '{event_tick: eff_time + {8'd0, held_duration}, event_kind: KIND_NOTE_OFF,
            note_or_program: held_note[6:0], velocity: 7'd0,
            event_channel: out_channel, last_of_run: 1'b1};

    if (active) begin
      byte_position_next = eff_pos + 10'd1;
      if (eff_left != 2'd0) begin
        if (eff_pend == OP_NOTE) begin
          if (eff_left == 2'd3) begin
            held_note_next = b;
          end else if (eff_left == 2'd2) begin
            held_duration_next = (b == 8'd0) ? 8'd1 : b;
          end else begin
            if (held_note <= MAX_DATA7) begin
              push_n = 2'd2;
            end
            track_time_next = eff_time + {8'd0, held_duration};
          end
        end else if (eff_pend == OP_PROGRAM) begin
          ev0.event_kind      = KIND_PROGRAM;
          ev0.note_or_program = b[6:0];
          ev0.velocity        = 7'd0;
          ev0.last_of_run     = 1'b1;
          push_n              = 2'd1;
        end
        operand_bytes_left_next = eff_left - 2'd1;
        if (eff_left == 2'd1) begin
          pending_opcode_next = OP_NONE;
        end
      end else if ({19'd0, eff_events} >= EV_LIMIT_V) begin
        // Event budget used up: halt and leave the position where it is.
        track_halted_next  = 1'b1;
        byte_position_next = eff_pos;
      end else begin
        case (b) inside
          OP_NOTE: begin
            if (room >= 10'd3) begin
              pending_opcode_next     = b;
              operand_bytes_left_next = 2'd3;
            end
          end
          OP_PROGRAM, OP_SKIP1_A, OP_SKIP1_B, OP_SKIP1_C, OP_SKIP1_D,
          OP_SKIP1_E, OP_SKIP1_F, OP_SKIP1_G: begin
            if (room >= 10'd1) begin
              pending_opcode_next     = b;
              operand_bytes_left_next = 2'd1;
            end
          end
          OP_SKIP2_A, OP_SKIP2_B: begin
            if (room >= 10'd2) begin
              pending_opcode_next     = b;
              operand_bytes_left_next = 2'd2;
            end
          end
          default: begin
            // Delay bytes advance time; every other high byte, the no-op
            // opcode included, is skipped.
            if (b < 8'h80) begin
              track_time_next = eff_time + ((b > LONG_DELAY_TH) ? 16'd4 : 16'd1);
            end
          end
        endcase
      end
    end
    events_emitted_next = eff_events + {11'd0, push_n};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      track_length <= 10'd512;
      out_channel  <= 4'd0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TRACK_LENGTH) begin
        track_length <= cfg_wdata;
      end else begin
        out_channel <= cfg_wdata[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      track_time         <= '0;
      events_emitted     <= '0;
      pending_opcode     <= OP_NONE;
      operand_bytes_left <= '0;
      held_note          <= '0;
      held_duration      <= '0;
      track_halted       <= 1'b0;
    end else if (accept) begin
      byte_position      <= byte_position_next;
      track_time         <= track_time_next;
      events_emitted     <= events_emitted_next;
      pending_opcode     <= pending_opcode_next;
      operand_bytes_left <= operand_bytes_left_next;
      held_note          <= held_note_next;
      held_duration      <= held_duration_next;
      track_halted       <= track_halted_next;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + PW'(push_n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + (accept ? (PW+1)'(push_n) : '0) - (pop ? (PW+1)'(1) : '0);
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (accept && push_n != 2'd0) begin
      queue[wr_ptr] <= ev0;
      if (push_n == 2'd2) begin
        queue[wr_ptr + PW'(1)] <= ev1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(DEPTH))
    else $error("event queue overfilled");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && !(accept && push_n != 2'd0)) |=> count == $past(count) - (PW+1)'(1))
    else $error("queue count did not drop on a pop");

  a_event_count: assert property (@(posedge clk) disable iff (rst)
    (accept && !in_data.song_start) |=>
      events_emitted == $past(events_emitted) + {11'd0, $past(push_n)})
    else $error("event count out of step with queued events");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && track_halted && !in_data.track_start && !in_data.song_start) |->
      push_n == 2'd0)
    else $error("halted track produced an event");
`endif

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for music_track_bytecode_to_note_events_core: it feeds
// track bytes, predicts the note and program events, and checks every event word.
// Depends on mtbne_pkg and the core module only.
module testbench;
  import mtbne_pkg::*;

  localparam int TRACK_CAP     = 512;
  localparam int EVENT_CAP     = 4096;
  localparam int LONG_DELAY    = 4;
  localparam int SHORT_DELAY   = 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int REPORT_LIMIT  = 10;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  in_word_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_word_t  out_data;
  logic       cfg_we;
  logic       cfg_index;
  logic [9:0] cfg_wdata;

  music_track_bytecode_to_note_events_core #(
    .MAX_TRACK_BYTES(TRACK_CAP),
    .MAX_EVENTS(EVENT_CAP)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Decoder state as the testbench tracks it, next to its own copy of the
  // two configuration registers.
  logic [9:0]  trk_len;
  logic [3:0]  out_chan;
  logic [9:0]  pos;
  logic [15:0] ttime;
  logic [12:0] ev_count;
  logic [7:0]  pend_op;
  logic [1:0]  ops_left;
  logic [7:0]  note_hold;
  logic [7:0]  dur_hold;
  logic        halted;

  // Track bytes waiting to be driven, and event words still owed by the block.
  in_word_t  byte_queue[$];
  out_word_t expected_events[$];

  int cycle_count;
  int bytes_accepted;
  int events_checked;
  int mismatches;
  int idle_pct;
  int in_gap;
  int out_gap;
  bit in_fired;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Queue one event word as the block should emit it and count it against
  // the per-song event budget.
  task automatic emit_event(input logic [15:0] tick, input logic [1:0] kind,
                            input logic [6:0] val, input logic [6:0] vel);
    out_word_t ev;
    ev.event_tick      = tick;
    ev.event_kind      = kind;
    ev.note_or_program = val;
    ev.velocity        = vel;
    ev.event_channel   = out_chan;
    ev.last_of_run     = 1'b0;
    expected_events.push_back(ev);
    ev_count = ev_count + 13'd1;
  endtask

  // Advance the decoder by one accepted byte word and queue its events.
  task automatic decode_byte(input in_word_t w);
    logic [7:0] b;
    logic [9:0] len_eff;
    logic [6:0] vel;
    int         room;
    int         n_events;
    b = w.data_byte;
    n_events = 0;
    // Both start flags act before the byte itself is looked at.
    if (w.track_start) begin
      pos = '0;
      ttime = '0;
      pend_op = OP_NONE;
      ops_left = '0;
      halted = 1'b0;
    end
    if (w.song_start) begin
      ev_count = '0;
      halted = 1'b0;
    end
    len_eff = (trk_len > TRACK_CAP) ? 10'(TRACK_CAP) : trk_len;
    // A halted track, or a byte beyond the track's end, is dropped and the
    // position stays where it is.
    if (halted || pos >= len_eff) return;
    if (ops_left != 2'd0) begin
      if (pend_op == OP_NOTE) begin
        if (ops_left == 2'd3) begin
          note_hold = b;
        end else if (ops_left == 2'd2) begin
          dur_hold = (b == 8'd0) ? 8'd1 : b;
        end else begin
          vel = (b == 8'd0 || b > MAX_DATA7) ? DEFAULT_VEL : b[6:0];
          // A note number above 127 makes no events but still takes time.
          if (note_hold <= MAX_DATA7) begin
            emit_event(ttime, KIND_NOTE_ON, note_hold[6:0], vel);
            emit_event(ttime + 16'(dur_hold), KIND_NOTE_OFF, note_hold[6:0], 7'd0);
            n_events = 2;
          end
          ttime = ttime + 16'(dur_hold);
        end
      end else if (pend_op == OP_PROGRAM) begin
        emit_event(ttime, KIND_PROGRAM, b[6:0], 7'd0);
        n_events = 1;
      end
      ops_left = ops_left - 2'd1;
      if (ops_left == 2'd0) pend_op = OP_NONE;
    end else if (ev_count >= 13'(EVENT_CAP - 2)) begin
      // Out of event slots: the track stops until the next track or song start.
      halted = 1'b1;
      return;
    end else begin
      // An opcode whose operands would run past the end is a one-byte skip.
      room = int'(len_eff) - int'(pos) - 1;
      case (b)
        OP_NOTE: begin
          if (room >= 3) begin
            pend_op = b;
            ops_left = 2'd3;
          end
        end
        OP_PROGRAM, OP_SKIP1_A, OP_SKIP1_B, OP_SKIP1_C, OP_SKIP1_D, OP_SKIP1_E,
        OP_SKIP1_F, OP_SKIP1_G: begin
          if (room >= 1) begin
            pend_op = b;
            ops_left = 2'd1;
          end
        end
        OP_SKIP2_A, OP_SKIP2_B: begin
          if (room >= 2) begin
            pend_op = b;
            ops_left = 2'd2;
          end
        end
        default: begin
          if (b <= MAX_DATA7)
            ttime = ttime + ((b > LONG_DELAY_TH) ? 16'(LONG_DELAY) : 16'(SHORT_DELAY));
        end
      endcase
    end
    pos = pos + 10'd1;
    if (n_events != 0)
      expected_events[expected_events.size() - 1].last_of_run = 1'b1;
  endtask

  // Compare one accepted event word with the oldest one still owed.
  task automatic check_event(input out_word_t got);
    out_word_t want;
    if (expected_events.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("unexpected event word: tick %0d kind %0d value %0d vel %0d ch %0d last %0b",
                 got.event_tick, got.event_kind, got.note_or_program, got.velocity,
                 got.event_channel, got.last_of_run);
      return;
    end
    want = expected_events.pop_front();
    events_checked++;
    if (got.event_tick !== want.event_tick || got.event_kind !== want.event_kind ||
        got.note_or_program !== want.note_or_program || got.velocity !== want.velocity ||
        got.event_channel !== want.event_channel || got.last_of_run !== want.last_of_run) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("event %0d expected: tick %0d kind %0d value %0d vel %0d ch %0d last %0b",
                 events_checked, want.event_tick, want.event_kind, want.note_or_program,
                 want.velocity, want.event_channel, want.last_of_run);
        $display("event %0d actual:   tick %0d kind %0d value %0d vel %0d ch %0d last %0b",
                 events_checked, got.event_tick, got.event_kind, got.note_or_program,
                 got.velocity, got.event_channel, got.last_of_run);
      end
    end
  endtask

  // Monitor and predictor share one clocked block, so an event word is always
  // checked before the byte accepted at the same edge adds new expectations.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d event words still owed",
               cycle_count, expected_events.size());
      $display("[music_track_bytecode_to_note_events_core] ERROR");
      $finish;
    end else begin
      in_fired = !rst && in_valid && in_ready;
      if (!rst) begin
        if (out_valid && out_ready) check_event(out_data);
        if (cfg_we) begin
          if (cfg_index == CFG_TRACK_LENGTH) trk_len = cfg_wdata;
          else out_chan = cfg_wdata[3:0];
        end
        if (in_fired) begin
          bytes_accepted++;
          decode_byte(in_data);
        end
      end
    end
  end

  // Byte driver: a word stays on in_data with in_valid high until it is taken;
  // between words it may hold in_valid low for an idle burst.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (in_gap != 0) begin
        in_gap = in_gap - 1;
        in_valid <= 1'b0;
      end else if (byte_queue.size() != 0 && idle_pct != 0 &&
                   $urandom_range(99) < idle_pct) begin
        in_gap = $urandom_range(7);
        in_valid <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        in_data <= byte_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Event receiver: stalls in bursts too, at about half the sender's rate.
  always @(negedge clk) begin
    if (out_gap != 0) begin
      out_gap = out_gap - 1;
      out_ready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(199) < idle_pct) begin
      out_gap = $urandom_range(7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic ts, input logic ss);
    in_word_t w;
    w.data_byte = b;
    w.track_start = ts;
    w.song_start = ss;
    byte_queue.push_back(w);
  endtask

  task automatic write_reg(input logic idx, input logic [9:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold off until every byte is taken and every event word has come back,
  // then let it run on for SETTLE_CYCLES to finish bytes that make no events.
  task automatic wait_idle();
    while (byte_queue.size() != 0 || in_valid || expected_events.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // A track byte with occasional stray start flags, so that tracks and songs
  // also get cut off in the middle of an opcode.
  task automatic queue_track_byte(input logic [7:0] b, input bit new_song,
                                  inout bit first, inout int made);
    logic ts;
    logic ss;
    ts = first || ($urandom_range(99) < 2);
    ss = (first && new_song) || ($urandom_range(99) < 1);
    send_byte(b, ts, ss);
    first = 1'b0;
    made++;
  endtask

  // One track of mostly well-formed opcodes with random operands; about a
  // fifth of the picks are a single plain noise byte.
  task automatic queue_random_track(input int nbytes, input bit new_song);
    logic [7:0] skip_one_ops[7];
    logic [7:0] note;
    int         made;
    int         r;
    bit         first;
    skip_one_ops = '{OP_SKIP1_A, OP_SKIP1_B, OP_SKIP1_C, OP_SKIP1_D,
                     OP_SKIP1_E, OP_SKIP1_F, OP_SKIP1_G};
    made = 0;
    first = 1'b1;
    while (made < nbytes) begin
      r = $urandom_range(99);
      if (r < 30) begin
        note = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 128))
                                        : 8'($urandom_range(127));
        queue_track_byte(OP_NOTE, new_song, first, made);
        queue_track_byte(note, new_song, first, made);
        queue_track_byte(($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(255)),
                         new_song, first, made);
        queue_track_byte(8'($urandom_range(255)), new_song, first, made);
      end else if (r < 40) begin
        queue_track_byte(OP_PROGRAM, new_song, first, made);
        queue_track_byte(8'($urandom_range(255)), new_song, first, made);
      end else if (r < 50) begin
        queue_track_byte(skip_one_ops[$urandom_range(6)], new_song, first, made);
        queue_track_byte(8'($urandom_range(255)), new_song, first, made);
      end else if (r < 57) begin
        queue_track_byte($urandom_range(1) ? OP_SKIP2_A : OP_SKIP2_B, new_song, first, made);
        queue_track_byte(8'($urandom_range(255)), new_song, first, made);
        queue_track_byte(8'($urandom_range(255)), new_song, first, made);
      end else if (r < 62) begin
        queue_track_byte(OP_NOP, new_song, first, made);
      end else if (r < 80) begin
        queue_track_byte(8'($urandom_range(127)), new_song, first, made);
      end else begin
        queue_track_byte(8'($urandom_range(255)), new_song, first, made);
      end
    end
  endtask

  // One configuration setting followed by random tracks. Tracks on short
  // lengths run a few bytes past the end; long lengths get shorter tracks.
  task automatic run_random_phase(input int len, input int chan, input int idle,
                                  input int nbytes);
    int queued;
    int track_bytes;
    int span;
    wait_idle();
    write_reg(CFG_TRACK_LENGTH, 10'(len));
    write_reg(CFG_OUT_CHANNEL, {6'($urandom_range(63)), 4'(chan)});
    idle_pct = idle;
    span = (len == 0) ? 8 : ((len > TRACK_CAP) ? TRACK_CAP : len);
    queued = 0;
    while (queued < nbytes) begin
      track_bytes = (span > 120) ? $urandom_range(120, 30) : span + $urandom_range(3);
      queue_random_track(track_bytes, $urandom_range(3) == 0);
      queued += track_bytes;
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_TRACK_LENGTH;
    cfg_wdata = '0;
    trk_len = 10'(TRACK_CAP);
    out_chan = '0;
    pos = '0;
    ttime = '0;
    ev_count = '0;
    pend_op = OP_NONE;
    ops_left = '0;
    note_hold = '0;
    dur_hold = '0;
    halted = 1'b0;
    cycle_count = 0;
    bytes_accepted = 0;
    events_checked = 0;
    mismatches = 0;
    idle_pct = 20;
    in_gap = 0;
    out_gap = 0;
    in_fired = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed bytes on the reset configuration: both delay sizes around the
    // threshold, a zero duration and zero velocity, the largest note with an
    // out-of-range velocity, a note above 127, a program number with its top
    // bit set, and skips whose operands look like opcodes.
    send_byte(8'h05, 1'b1, 1'b1);
    send_byte(8'h21, 1'b0, 1'b0);
    send_byte(LONG_DELAY_TH, 1'b0, 1'b0);
    send_byte(MAX_DATA7, 1'b0, 1'b0);
    send_byte(OP_NOTE, 1'b0, 1'b0);
    send_byte(8'h3C, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(OP_NOTE, 1'b0, 1'b0);
    send_byte(MAX_DATA7, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(OP_NOTE, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h10, 1'b0, 1'b0);
    send_byte(8'h40, 1'b0, 1'b0);
    send_byte(OP_PROGRAM, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(OP_SKIP1_A, 1'b0, 1'b0);
    send_byte(OP_NOTE, 1'b0, 1'b0);
    send_byte(OP_SKIP2_A, 1'b0, 1'b0);
    send_byte(OP_PROGRAM, 1'b0, 1'b0);
    send_byte(OP_NOTE, 1'b0, 1'b0);
    send_byte(OP_NOP, 1'b0, 1'b0);
    send_byte(8'h81, 1'b0, 1'b0);

    // A four-byte track: opcodes too close to the end turn into one-byte
    // skips, bytes past the end are dropped, and a note that exactly fits
    // still plays.
    wait_idle();
    write_reg(CFG_TRACK_LENGTH, 10'd4);
    write_reg(CFG_OUT_CHANNEL, 10'd15);
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(OP_NOTE, 1'b0, 1'b0);
    send_byte(OP_SKIP2_B, 1'b0, 1'b0);
    send_byte(OP_PROGRAM, 1'b0, 1'b0);
    send_byte(8'h05, 1'b0, 1'b0);
    send_byte(OP_NOTE, 1'b1, 1'b0);
    send_byte(8'h10, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h50, 1'b0, 1'b0);
    send_byte(8'h02, 1'b0, 1'b0);

    // Random tracks over the length extremes (zero drops everything and a
    // length above the cap acts as the cap).
    run_random_phase(1, 15, 30, 60);
    run_random_phase(0, 3, 30, 30);
    run_random_phase(1023, $urandom_range(15), 30, 100);
    run_random_phase($urandom_range(40, 2), $urandom_range(15), 0, 150);
    run_random_phase($urandom_range(64, 4), $urandom_range(15), 40, 150);
    run_random_phase(TRACK_CAP, 0, 20, 100);
    // The closing stretch runs with no idling on either side.
    run_random_phase($urandom_range(48, 8), $urandom_range(15), 0, 120);
    wait_idle();

    $display("decoded %0d track bytes into %0d checked event words, %0d mismatches",
             bytes_accepted, events_checked, mismatches);
    $display("track lengths 0, 1, 4, 512 and above the cap, with stalls on both sides");
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("[music_track_bytecode_to_note_events_core] OK");
    end else begin
      $display("[music_track_bytecode_to_note_events_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/mtbne_pkg.sv
hw/rtl/music_track_bytecode_to_note_events_core.sv
dv/testbench.sv
